/* src/uipip_pkg.sv */
// Shared types and constants for the UDP service IPIP encapsulator.
`default_nettype none
package uipip_pkg;

   typedef enum logic [1:0] {
      VERDICT_ABORTED  = 2'd0,
      VERDICT_PASS     = 2'd1,
      VERDICT_REDIRECT = 2'd2
   } verdict_type;

   typedef enum logic [3:0] {
      CSR_BALANCER_ADDRESS = 4'd0,
      CSR_EGRESS_ADDRESS   = 4'd1,
      CSR_EGRESS_MAC       = 4'd2,
      CSR_BACKEND_ADDRESS  = 4'd3,
      CSR_BACKEND_MAC      = 4'd4,
      CSR_EGRESS_INTERFACE = 4'd5,
      CSR_SERVICE_PORT     = 4'd6,
      CSR_FRAGMENT_MASK    = 4'd7
   } csr_index_type;

   localparam int unsigned REQ_DATA_W = 128;
   localparam int unsigned RSP_DATA_W = 232;
   localparam int unsigned CSR_DATA_W = 48;

   localparam logic [15:0] ETHER_IPV4     = 16'h0800;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [3:0]  IHL_PLAIN      = 4'd5;
   localparam logic [15:0] MIN_ETH_BYTES  = 16'd14;
   localparam logic [15:0] MIN_IP_BYTES   = 16'd34;
   localparam logic [15:0] MIN_UDP_BYTES  = 16'd42;
   localparam logic [15:0] IP_HDR_BYTES   = 16'd20;
   // version/IHL/TOS word and TTL/protocol word of the outer header
   localparam logic [15:0] OUTER_VER_TOS  = 16'h4500;
   localparam logic [15:0] OUTER_TTL_PROT = 16'h0804;

   localparam logic [15:0] SERVICE_PORT_RESET  = 16'd7000;
   localparam logic [15:0] FRAGMENT_MASK_RESET = 16'h3fff;

   typedef struct packed {
      logic [31:0] balancer_address;
      logic [31:0] egress_address;
      logic [47:0] egress_mac;
      logic [31:0] backend_address;
      logic [47:0] backend_mac;
      logic [31:0] egress_interface;
      logic [15:0] service_port;
      logic [15:0] fragment_mask;
   } cfg_type;

   typedef struct packed {
      logic [15:0] udp_destination;
      logic [31:0] source_address;
      logic [15:0] inner_length;
      logic [15:0] flags_offset;
      logic [7:0]  ip_protocol;
      logic [3:0]  header_words;
      logic [15:0] ether_type;
      logic [15:0] frame_length;
   } hdr_type;

   typedef struct packed {
      verdict_type verdict;
      logic [15:0] inner_length;
   } entry_type;

   typedef struct packed {
      logic [31:0] out_interface;
      logic [15:0] outer_checksum;
      logic [31:0] outer_dest;
      logic [31:0] outer_source;
      logic [15:0] outer_length;
      logic [47:0] out_source_mac;
      logic [47:0] out_dest_mac;
      logic [1:0]  verdict;
   } result_type;

endpackage
`default_nettype wire

/* src/uipip_front.sv */
// Front end: classifies one parsed header into a verdict.
`default_nettype none
module uipip_front (
   input  var uipip_pkg::hdr_type   hdr,
   input  var uipip_pkg::cfg_type   cfg,
   output uipip_pkg::entry_type     entry
);
   import uipip_pkg::*;

   verdict_type verdict;

   always_comb begin
      if (hdr.frame_length < MIN_ETH_BYTES) begin
         verdict = VERDICT_ABORTED;
      end else if (hdr.ether_type != ETHER_IPV4) begin
         verdict = VERDICT_PASS;
      end else if (hdr.frame_length < MIN_IP_BYTES) begin
         verdict = VERDICT_ABORTED;
      end else if (hdr.header_words != IHL_PLAIN) begin
         verdict = VERDICT_ABORTED;
      end else if (hdr.ip_protocol != PROTO_UDP) begin
         verdict = VERDICT_PASS;
      end else if ((hdr.flags_offset & cfg.fragment_mask) != 16'd0) begin
         verdict = VERDICT_ABORTED;
      end else if (hdr.frame_length < MIN_UDP_BYTES) begin
         verdict = VERDICT_ABORTED;
      end else if (hdr.udp_destination != cfg.service_port) begin
         verdict = VERDICT_PASS;
      end else if (hdr.source_address == cfg.balancer_address) begin
         verdict = VERDICT_PASS;
      end else begin
         verdict = VERDICT_REDIRECT;
      end
   end

   assign entry.verdict      = verdict;
   assign entry.inner_length = hdr.inner_length;

endmodule
`default_nettype wire

/* src/uipip_fifo.sv */
// Short queue between the classifier and the header builder.
`default_nettype none
module uipip_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  var uipip_pkg::entry_type push_data,
   output logic                    full,
   input  wire                     pop,
   output uipip_pkg::entry_type    pop_data,
   output logic                    empty
);
   import uipip_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type        entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* src/uipip_back.sv */
// Back end: builds the outer header and checksum, holds the result register.
`default_nettype none
module uipip_back (
   input  wire                     clock,
   input  wire                     reset,
   input  var uipip_pkg::cfg_type   cfg,
   input  var uipip_pkg::entry_type entry,
   input  wire                     entry_valid,
   output logic                    entry_pop,
   output logic                    out_valid,
   input  wire                     out_ready,
   output uipip_pkg::result_type   out_result
);
   import uipip_pkg::*;

   logic        valid_ff, valid_in;
   result_type  result_ff, result_in;
   logic        load;
   logic        redirect;
   logic [15:0] outer_len;
   logic [18:0] sum;
   logic [16:0] fold1;
   logic [15:0] fold2;

   assign load      = entry_valid && (!valid_ff || out_ready);
   assign entry_pop = load;
   assign redirect  = (entry.verdict == VERDICT_REDIRECT);
   assign outer_len = entry.inner_length + IP_HDR_BYTES;

   // ten header words; id, flags and checksum words are zero
   assign sum = 19'(OUTER_VER_TOS) + 19'(OUTER_TTL_PROT) + 19'(outer_len)
              + 19'(cfg.egress_address[31:16]) + 19'(cfg.egress_address[15:0])
              + 19'(cfg.backend_address[31:16]) + 19'(cfg.backend_address[15:0]);
   // two folds suffice: the second carry cannot ripple out again
   assign fold1 = 17'(sum[15:0]) + 17'(sum[18:16]);
   assign fold2 = fold1[15:0] + 16'(fold1[16]);

   always_comb begin
      result_in = '0;
      result_in.verdict = entry.verdict;
      if (redirect) begin
         result_in.out_dest_mac   = cfg.backend_mac;
         result_in.out_source_mac = cfg.egress_mac;
         result_in.outer_length   = outer_len;
         result_in.outer_source   = cfg.egress_address;
         result_in.outer_dest     = cfg.backend_address;
         result_in.outer_checksum = ~fold2;
         result_in.out_interface  = cfg.egress_interface;
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule
`default_nettype wire

/* src/udp_service_ipip_encapsulator_unit.sv */
// UDP service IPIP encapsulator: top level with the register file.
//
// req_ carries one frame's parsed header per transfer; rsp_ returns one
// verdict per header (aborted, pass, redirect) and, on redirect, the
// outer IPv4 header fields, new MAC addresses and egress interface.
// Non-redirect results carry zeros in every field but the verdict.
// csr_ writes one register per transfer (index, data); csr_ready is
// always high. Write registers only while no header is in flight.
// Throughput: one header per cycle while rsp_tready is high. Each header
// passes through the queue register and then the result register before
// its result is offered.
// When the receiver stalls, the result register holds and the queue
// (QUEUE_DEPTH entries) fills; req_tready drops once it is full.
// Reset (synchronous) empties the queue, drops rsp_tvalid and loads the
// register reset values (service port 7000, fragment mask 0x3fff).
`default_nettype none
module udp_service_ipip_encapsulator_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // frame_length, ether_type, header_words, ip_protocol, flags_offset,
   // inner_length, source_address, udp_destination, zero pad
   input  wire  [uipip_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // verdict, out_dest_mac, out_source_mac, outer_length, outer_source,
   // outer_dest, outer_checksum, out_interface, zero pad
   output logic [uipip_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [3:0]                           csr_index,
   input  wire  [uipip_pkg::CSR_DATA_W-1:0]     csr_data
);
   import uipip_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   hdr_type    hdr;
   entry_type  push_entry, pop_entry;
   logic       queue_full, queue_empty, queue_pop;
   result_type result;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BALANCER_ADDRESS: cfg_in.balancer_address = csr_data[31:0];
            CSR_EGRESS_ADDRESS:   cfg_in.egress_address   = csr_data[31:0];
            CSR_EGRESS_MAC:       cfg_in.egress_mac       = csr_data[47:0];
            CSR_BACKEND_ADDRESS:  cfg_in.backend_address  = csr_data[31:0];
            CSR_BACKEND_MAC:      cfg_in.backend_mac      = csr_data[47:0];
            CSR_EGRESS_INTERFACE: cfg_in.egress_interface = csr_data[31:0];
            CSR_SERVICE_PORT:     cfg_in.service_port     = csr_data[15:0];
            CSR_FRAGMENT_MASK:    cfg_in.fragment_mask    = csr_data[15:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // service port and fragment mask are the two lowest fields
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cfg_type'({{($bits(cfg_type) - 32){1'b0}},
                              SERVICE_PORT_RESET, FRAGMENT_MASK_RESET});
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign hdr        = hdr_type'(req_tdata[$bits(hdr_type)-1:0]);
   assign req_tready = !queue_full;

   uipip_front u_front (
      .hdr   (hdr),
      .cfg   (cfg_ff),
      .entry (push_entry)
   );

   uipip_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_data (push_entry),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (pop_entry),
      .empty     (queue_empty)
   );

   uipip_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .entry       (pop_entry),
      .entry_valid (!queue_empty),
      .entry_pop   (queue_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (result)
   );

   assign rsp_tdata = {(RSP_DATA_W - $bits(result_type))'(0), result};

endmodule
`default_nettype wire
